// ----- design/wlss_pkg.sv -----
// shared types, codes and constants of the wav lsb stego stream block
package wlss_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_RIFF    = 3'd0,
        PH_CHUNK   = 3'd1,
        PH_FMT     = 3'd2,
        PH_SKIP    = 3'd3,
        PH_SAMPLES = 3'd4
    } phase_t;

    // header lengths and positions
    localparam logic [4:0] RIFF_HDR_LEN   = 5'd12;
    localparam logic [4:0] FMT_BODY_LEN   = 5'd16;
    localparam logic [4:0] FMT_BPS_POS    = 5'd14;
    localparam logic [4:0] CHUNK_HDR_LEN  = 5'd8;
    localparam logic [4:0] CHUNK_ID_LEN   = 5'd4;
    localparam logic [7:0] MIN_BITS       = 8'd8;
    localparam logic [3:0] MAX_SAMPLE_BYTES = 4'd8;

    // four-character codes, first byte in low bits
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    // error flag bit positions
    localparam int unsigned ERR_HEADER = 0;
    localparam int unsigned ERR_FORMAT = 1;

    // one input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       message_bit;
    } item_t;

    // one result request
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        bit_valid;
        logic        extracted_bit;
        logic        in_samples;
        logic        header_error;
        logic        format_error;
        logic        chunk_done;
        logic [31:0] chunk_id;
        logic [31:0] chunk_size;
        logic [7:0]  bits_per_sample;
    } result_t;

endpackage

// ----- design/wlss_ifs.sv -----
// valid/ready channel interfaces for byte input, results and configuration

// byte input channel
interface wlss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       message_bit;

    modport source (output valid, output in_byte, output message_bit, input ready);
    modport sink   (input valid, input in_byte, input message_bit, output ready);
endinterface

// result channel
interface wlss_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        bit_valid;
    logic        extracted_bit;
    logic        in_samples;
    logic        header_error;
    logic        format_error;
    logic        chunk_done;
    logic [31:0] chunk_id;
    logic [31:0] chunk_size;
    logic [7:0]  bits_per_sample;

    modport source (
        output valid, input ready,
        output out_byte, output bit_valid, output extracted_bit, output in_samples,
        output header_error, output format_error, output chunk_done,
        output chunk_id, output chunk_size, output bits_per_sample
    );
    modport sink (
        input valid, output ready,
        input out_byte, input bit_valid, input extracted_bit, input in_samples,
        input header_error, input format_error, input chunk_done,
        input chunk_id, input chunk_size, input bits_per_sample
    );
endinterface

// configuration write channel
interface wlss_cfg_if;
    logic valid;
    logic ready;
    logic embed_mode;

    modport source (output valid, output embed_mode, input ready);
    modport sink   (input valid, input embed_mode, output ready);
endinterface

// ----- design/wlss_in_stage.sv -----
// input register holding one accepted byte request until the parser takes it
module wlss_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            feed_valid,
    input  wlss_pkg::item_t feed_item,
    output logic            feed_ready,
    input  logic            take,
    output logic            item_valid,
    output wlss_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    wlss_pkg::item_t item_reg;

    // room when empty or when the held request leaves this cycle
    assign feed_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (feed_ready)
        begin
            valid_next = feed_valid;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded on accept
    always_ff @(posedge clk)
    begin
        if (feed_ready && feed_valid)
        begin
            item_reg <= feed_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- design/wlss_parser.sv -----
// wav chunk walker, lsb extract/embed logic and result register
module wlss_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              embed_mode,
    input  logic              item_valid,
    input  wlss_pkg::item_t   item,
    output logic              take,
    input  logic              res_ready,
    output logic              res_valid,
    output wlss_pkg::result_t res
);

    wlss_pkg::phase_t  phase_reg, phase_next;
    logic [4:0]        field_count_reg, field_count_next;
    logic [31:0]       id_shift_reg, id_shift_next;
    logic [31:0]       size_shift_reg, size_shift_next;
    logic [31:0]       skip_left_reg, skip_left_next;
    logic [7:0]        sample_bits_reg, sample_bits_next;
    logic [2:0]        sample_byte_index_reg, sample_byte_index_next;
    logic [1:0]        error_flags_reg, error_flags_next;
    logic              res_valid_reg, res_valid_next;
    wlss_pkg::result_t res_reg, res_next;

    logic [8:0]  bits_round;
    logic [5:0]  bytes_raw;
    logic [3:0]  bytes_per_sample;
    logic [3:0]  index_inc;
    logic [4:0]  count_inc;
    logic [31:0] skip_dec;
    logic [31:0] byte_shift;
    logic [7:0]  b;

    // result slot free when empty or being drained
    assign take = item_valid && (!res_valid_reg || res_ready);

    // bytes per sample: ceil(bits/8), clamped to one..eight
    assign bits_round = {1'b0, sample_bits_reg} + 9'd7;
    assign bytes_raw  = bits_round[8:3];
    always_comb
    begin
        if (bytes_raw == 6'd0)
        begin
            bytes_per_sample = 4'd1;
        end
        else if (bytes_raw > {2'b00, wlss_pkg::MAX_SAMPLE_BYTES})
        begin
            bytes_per_sample = wlss_pkg::MAX_SAMPLE_BYTES;
        end
        else
        begin
            bytes_per_sample = bytes_raw[3:0];
        end
    end

    assign b          = item.in_byte;
    assign index_inc  = {1'b0, sample_byte_index_reg} + 4'd1;
    assign count_inc  = field_count_reg + 5'd1;
    assign skip_dec   = (skip_left_reg != 32'd0) ? (skip_left_reg - 32'd1) : 32'd0;
    assign byte_shift = {b, 24'd0};

    // next state and result for the held byte
    always_comb
    begin
        phase_next             = phase_reg;
        field_count_next       = field_count_reg;
        id_shift_next          = id_shift_reg;
        size_shift_next        = size_shift_reg;
        skip_left_next         = skip_left_reg;
        sample_bits_next       = sample_bits_reg;
        sample_byte_index_next = sample_byte_index_reg;
        error_flags_next       = error_flags_reg;
        res_next               = '0;
        res_next.out_byte      = b;

        unique case (phase_reg)
            wlss_pkg::PH_RIFF:
            begin
                id_shift_next    = (id_shift_reg >> 8) | byte_shift;
                field_count_next = count_inc;
                if (count_inc >= wlss_pkg::RIFF_HDR_LEN)
                begin
                    if (id_shift_next != wlss_pkg::ID_WAVE)
                    begin
                        error_flags_next[wlss_pkg::ERR_HEADER] = 1'b1;
                    end
                    field_count_next = 5'd0;
                    phase_next       = wlss_pkg::PH_CHUNK;
                end
            end
            wlss_pkg::PH_FMT:
            begin
                if (field_count_reg == wlss_pkg::FMT_BPS_POS)
                begin
                    sample_bits_next = b;
                end
                field_count_next = count_inc;
                if (count_inc >= wlss_pkg::FMT_BODY_LEN)
                begin
                    field_count_next = 5'd0;
                    phase_next       = wlss_pkg::PH_CHUNK;
                end
            end
            wlss_pkg::PH_SKIP:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    field_count_next = 5'd0;
                    phase_next       = wlss_pkg::PH_CHUNK;
                end
            end
            wlss_pkg::PH_SAMPLES:
            begin
                res_next.in_samples = 1'b1;
                if (sample_byte_index_reg == 3'd0)
                begin
                    res_next.bit_valid     = 1'b1;
                    res_next.extracted_bit = b[0];
                    if (embed_mode)
                    begin
                        res_next.out_byte = {b[7:1], item.message_bit};
                    end
                end
                if (index_inc >= bytes_per_sample)
                begin
                    sample_byte_index_next = 3'd0;
                end
                else
                begin
                    sample_byte_index_next = index_inc[2:0];
                end
            end
            default:
            begin
                // chunk header, also taken for unused phase codes
                if (field_count_reg < wlss_pkg::CHUNK_ID_LEN)
                begin
                    id_shift_next = (id_shift_reg >> 8) | byte_shift;
                end
                else
                begin
                    size_shift_next = (size_shift_reg >> 8) | byte_shift;
                end
                field_count_next = count_inc;
                phase_next       = wlss_pkg::PH_CHUNK;
                if (count_inc >= wlss_pkg::CHUNK_HDR_LEN)
                begin
                    res_next.chunk_done = 1'b1;
                    field_count_next    = 5'd0;
                    if (id_shift_next == wlss_pkg::ID_FMT)
                    begin
                        phase_next = wlss_pkg::PH_FMT;
                    end
                    else if (id_shift_next == wlss_pkg::ID_DATA)
                    begin
                        phase_next             = wlss_pkg::PH_SAMPLES;
                        sample_byte_index_next = 3'd0;
                        if (sample_bits_reg < wlss_pkg::MIN_BITS)
                        begin
                            error_flags_next[wlss_pkg::ERR_FORMAT] = 1'b1;
                        end
                    end
                    else if (size_shift_next != 32'd0)
                    begin
                        skip_left_next = size_shift_next;
                        phase_next     = wlss_pkg::PH_SKIP;
                    end
                end
            end
        endcase

        res_next.header_error    = error_flags_next[wlss_pkg::ERR_HEADER];
        res_next.format_error    = error_flags_next[wlss_pkg::ERR_FORMAT];
        res_next.chunk_id        = id_shift_next;
        res_next.chunk_size      = size_shift_next;
        res_next.bits_per_sample = sample_bits_next;
    end

    // result valid flag
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // parser state, updated once per taken byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= wlss_pkg::PH_RIFF;
            field_count_reg       <= 5'd0;
            id_shift_reg          <= 32'd0;
            size_shift_reg        <= 32'd0;
            skip_left_reg         <= 32'd0;
            sample_bits_reg       <= 8'd0;
            sample_byte_index_reg <= 3'd0;
            error_flags_reg       <= 2'd0;
            res_valid_reg         <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                phase_reg             <= phase_next;
                field_count_reg       <= field_count_next;
                id_shift_reg          <= id_shift_next;
                size_shift_reg        <= size_shift_next;
                skip_left_reg         <= skip_left_next;
                sample_bits_reg       <= sample_bits_next;
                sample_byte_index_reg <= sample_byte_index_next;
                error_flags_reg       <= error_flags_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- design/wav_lsb_stego_stream.sv -----
// top level of the wav lsb steganography byte stream block
//
// usage:
//   feed   - one wav file byte per request with the message bit to hide
//   result - one result request per byte: the passed-through byte (lsb
//            replaced when embedding at a sample's first byte) and parse status
//   cfg    - writes embed_mode (0 extract, 1 embed); always ready, write only
//            while no byte is in flight
// path: a byte accepted on feed passes the input register, then the result
//   register, before it shows on result
// throughput: one byte per cycle while result is taken; the state update per
//   byte is a single short pass through the chunk walker between the two registers
// reset: parser returns to the riff header phase, flags and shifts clear,
//   embed_mode returns to extract
// stall: while result is held, the input register takes a byte only if it is
//   empty, then feed.ready stays low until the result is taken
module wav_lsb_stego_stream
(
    input  logic              clk,
    input  logic              rst_n,
    wlss_in_if.sink           feed,
    wlss_out_if.source        result,
    wlss_cfg_if.sink          cfg
);

    logic              embed_mode_reg;
    wlss_pkg::item_t   feed_item;
    wlss_pkg::item_t   item;
    logic              item_valid;
    logic              take;
    logic              res_valid;
    wlss_pkg::result_t res;

    // configuration register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            embed_mode_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            embed_mode_reg <= cfg.embed_mode;
        end
    end

    // input register
    assign feed_item.in_byte     = feed.in_byte;
    assign feed_item.message_bit = feed.message_bit;

    wlss_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed_valid (feed.valid),
        .feed_item  (feed_item),
        .feed_ready (feed.ready),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // parser and result register
    wlss_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .embed_mode (embed_mode_reg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_ready  (result.ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result channel
    assign result.valid           = res_valid;
    assign result.out_byte        = res.out_byte;
    assign result.bit_valid       = res.bit_valid;
    assign result.extracted_bit   = res.extracted_bit;
    assign result.in_samples      = res.in_samples;
    assign result.header_error    = res.header_error;
    assign result.format_error    = res.format_error;
    assign result.chunk_done      = res.chunk_done;
    assign result.chunk_id        = res.chunk_id;
    assign result.chunk_size      = res.chunk_size;
    assign result.bits_per_sample = res.bits_per_sample;

endmodule

// ----- design/wlss_checker.sv -----
// port-level checks of the wav lsb stego stream block, bound to the top level
module wlss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        bit_valid,
    input logic        extracted_bit,
    input logic        in_samples,
    input logic        chunk_done,
    input logic        header_error
);

    // a stalled result holds its byte
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("result byte changed while stalled");

    // a sample start only inside sample data
    a_bit_in_samples: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_valid |-> in_samples)
        else $error("bit_valid outside sample data");

    // extracted bit is zero unless a sample starts
    a_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bit_valid |-> !extracted_bit)
        else $error("extracted_bit set without bit_valid");

    // the last chunk header byte is never sample data
    a_done_not_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_done |-> !in_samples)
        else $error("chunk_done during sample data");

    // header error is sticky across taken results
    a_header_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_error |=> !out_valid || header_error)
        else $error("header_error cleared");

endmodule

bind wav_lsb_stego_stream wlss_checker u_wlss_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_byte      (result.out_byte),
    .bit_valid     (result.bit_valid),
    .extracted_bit (result.extracted_bit),
    .in_samples    (result.in_samples),
    .chunk_done    (result.chunk_done),
    .header_error  (result.header_error)
);
